// ----- src/i2c_register_access_master_macros.svh -----
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// next-cycle implication
`define I2CM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - package
// Types and constants used by the front queue and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam logic [6:0] DEV_ADDR_RESET = 7'h68;

  // line sequencer phases, one-hot
  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    PH_ST0  = 20'h00002,
    PH_ST1  = 20'h00004,
    PH_ST2  = 20'h00008,
    PH_ST3  = 20'h00010,
    PH_TXD  = 20'h00020,
    PH_TXH  = 20'h00040,
    PH_TXL  = 20'h00080,
    PH_AKD  = 20'h00100,
    PH_AKH  = 20'h00200,
    PH_AKL  = 20'h00400,
    PH_RXR  = 20'h00800,
    PH_RXH  = 20'h01000,
    PH_RXL  = 20'h02000,
    PH_MAD  = 20'h04000,
    PH_MAH  = 20'h08000,
    PH_MAL  = 20'h10000,
    PH_SPD  = 20'h20000,
    PH_SPH  = 20'h40000,
    PH_SPU  = 20'h80000
  } phase_t;

  // which byte is on the wire
  typedef enum logic [1:0] {
    KIND_DEVW = 2'd0,
    KIND_REG  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_DEVR = 2'd3
  } kind_t;

  // classified tick item held in the front queue
  typedef struct packed {
    logic       go;
    logic       mode;
    logic [7:0] reg_addr;
    logic [7:0] span;       // byte count, zero-length read already made one
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  // result of one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       data_taken;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       nack_seen;
    logic       done_res;
  } result_t;

endpackage

`default_nettype wire

// ----- src/i2cm_if.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - channel interfaces
// Valid/ready channels for tick items, results and the address register.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic       go;
  logic       mode;
  logic [7:0] reg_addr;
  logic [7:0] byte_count;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, go, mode, reg_addr, byte_count, write_data, sda_in,
                  input ready);
  modport sink   (input valid, go, mode, reg_addr, byte_count, write_data, sda_in,
                  output ready);
endinterface

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       data_taken;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       last_byte;
  logic       nack_seen;
  logic       done_res;

  modport source (output valid, scl_out, sda_out, busy_res, data_taken, read_valid,
                  read_byte, last_byte, nack_seen, done_res,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, data_taken, read_valid,
                  read_byte, last_byte, nack_seen, done_res,
                  output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] device_address;

  modport source (output valid, device_address, input ready);
  modport sink   (input valid, device_address, output ready);
endinterface

`default_nettype wire

// ----- src/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - front queue
// Accepts tick items, normalizes the byte count, holds them in a 2-entry FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  i2cm_req_if.sink            req,
  output i2cm_pkg::tick_t     head,
  output logic                head_valid,
  input  wire logic           pop
);

  i2cm_pkg::tick_t q_mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  i2cm_pkg::tick_t item;

  assign req.ready  = (count != 2'd2);
  assign push       = req.valid && req.ready;
  assign head       = q_mem[rd_ptr];
  assign head_valid = (count != 2'd0);

  always_comb begin
    item.go         = req.go;
    item.mode       = req.mode;
    item.reg_addr   = req.reg_addr;
    // a zero-length read moves one byte
    item.span       = (req.mode && req.byte_count == 8'd0) ? 8'd1 : req.byte_count;
    item.write_data = req.write_data;
    item.sda_in     = req.sda_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= item;
  end

endmodule

`default_nettype wire

// ----- src/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - line sequencer
// One line step per queued tick; result held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire i2cm_pkg::tick_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  i2cm_cfg_if.sink             cfg,
  i2cm_rsp_if.source           rsp
);

  logic [6:0]       device_address;

  i2cm_pkg::phase_t phase, phase_next;
  i2cm_pkg::kind_t  kind, kind_next;
  logic [3:0]       bit_index, bit_index_next;
  logic [7:0]       bytes_left, bytes_left_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic             is_read, is_read_next;
  logic [7:0]       reg_latch, reg_latch_next;
  logic             nack_flag, nack_flag_next;
  logic             scl_level, scl_level_next;
  logic             sda_level, sda_level_next;

  i2cm_pkg::result_t res_next;
  i2cm_pkg::result_t res;
  logic              res_valid;

  assign cfg.ready = 1'b1;
  assign pop       = head_valid && (!res_valid || rsp.ready);

  always_comb begin
    phase_next      = phase;
    kind_next       = kind;
    bit_index_next  = bit_index;
    bytes_left_next = bytes_left;
    shift_reg_next  = shift_reg;
    is_read_next    = is_read;
    reg_latch_next  = reg_latch;
    nack_flag_next  = nack_flag;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    res_next        = '0;
    res_next.busy_res = 1'b1;

    if (phase == i2cm_pkg::PH_IDLE && head.go) begin
      is_read_next    = head.mode;
      reg_latch_next  = head.reg_addr;
      bytes_left_next = head.span;
      kind_next       = i2cm_pkg::KIND_DEVW;
      nack_flag_next  = 1'b0;
      bit_index_next  = 4'd0;
      phase_next      = i2cm_pkg::PH_ST0;
    end

    unique case (phase_next)
      i2cm_pkg::PH_ST0: begin
        sda_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_ST1;
      end
      i2cm_pkg::PH_ST1: begin
        scl_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_ST2;
      end
      i2cm_pkg::PH_ST2: begin
        sda_level_next = 1'b0;
        phase_next     = i2cm_pkg::PH_ST3;
      end
      i2cm_pkg::PH_ST3: begin
        scl_level_next = 1'b0;
        bit_index_next = 4'd0;
        phase_next     = i2cm_pkg::PH_TXD;
      end
      i2cm_pkg::PH_TXD: begin
        if (bit_index_next == 4'd0) begin
          unique case (kind_next)
            i2cm_pkg::KIND_DEVW: shift_reg_next = {device_address, 1'b0};
            i2cm_pkg::KIND_DEVR: shift_reg_next = {device_address, 1'b1};
            i2cm_pkg::KIND_REG:  shift_reg_next = reg_latch_next;
            default: begin
              shift_reg_next      = head.write_data;
              res_next.data_taken = 1'b1;
            end
          endcase
        end
        sda_level_next = shift_reg_next[7];
        phase_next     = i2cm_pkg::PH_TXH;
      end
      i2cm_pkg::PH_TXH: begin
        scl_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_TXL;
      end
      i2cm_pkg::PH_TXL: begin
        scl_level_next = 1'b0;
        shift_reg_next = {shift_reg_next[6:0], 1'b0};
        bit_index_next = bit_index_next + 4'd1;
        phase_next     = (bit_index_next >= 4'd8) ? i2cm_pkg::PH_AKD : i2cm_pkg::PH_TXD;
      end
      i2cm_pkg::PH_AKD: begin
        sda_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_AKH;
      end
      i2cm_pkg::PH_AKH: begin
        scl_level_next = 1'b1;
        if (head.sda_in) nack_flag_next = 1'b1;
        phase_next     = i2cm_pkg::PH_AKL;
      end
      i2cm_pkg::PH_AKL: begin
        scl_level_next = 1'b0;
        bit_index_next = 4'd0;
        unique case (kind_next)
          i2cm_pkg::KIND_DEVW: begin
            kind_next  = i2cm_pkg::KIND_REG;
            phase_next = i2cm_pkg::PH_TXD;
          end
          i2cm_pkg::KIND_REG: begin
            if (is_read_next) begin
              // repeated start, then address with read bit
              kind_next  = i2cm_pkg::KIND_DEVR;
              phase_next = i2cm_pkg::PH_ST0;
            end else if (bytes_left_next == 8'd0) begin
              phase_next = i2cm_pkg::PH_SPD;
            end else begin
              kind_next  = i2cm_pkg::KIND_DATA;
              phase_next = i2cm_pkg::PH_TXD;
            end
          end
          i2cm_pkg::KIND_DATA: begin
            if (bytes_left_next != 8'd0) bytes_left_next = bytes_left_next - 8'd1;
            phase_next = (bytes_left_next == 8'd0) ? i2cm_pkg::PH_SPD : i2cm_pkg::PH_TXD;
          end
          default: phase_next = i2cm_pkg::PH_RXR;
        endcase
      end
      i2cm_pkg::PH_RXR: begin
        sda_level_next = 1'b1;
        bit_index_next = 4'd0;
        shift_reg_next = 8'd0;
        phase_next     = i2cm_pkg::PH_RXH;
      end
      i2cm_pkg::PH_RXH: begin
        scl_level_next = 1'b1;
        shift_reg_next = {shift_reg_next[6:0], head.sda_in};
        phase_next     = i2cm_pkg::PH_RXL;
      end
      i2cm_pkg::PH_RXL: begin
        scl_level_next = 1'b0;
        bit_index_next = bit_index_next + 4'd1;
        if (bit_index_next >= 4'd8) begin
          res_next.read_valid = 1'b1;
          res_next.read_byte  = shift_reg_next;
          res_next.last_byte  = (bytes_left_next <= 8'd1);
          phase_next          = i2cm_pkg::PH_MAD;
        end else begin
          phase_next = i2cm_pkg::PH_RXH;
        end
      end
      i2cm_pkg::PH_MAD: begin
        // nack the final byte, ack the rest
        sda_level_next = (bytes_left_next <= 8'd1);
        phase_next     = i2cm_pkg::PH_MAH;
      end
      i2cm_pkg::PH_MAH: begin
        scl_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_MAL;
      end
      i2cm_pkg::PH_MAL: begin
        scl_level_next = 1'b0;
        if (bytes_left_next != 8'd0) bytes_left_next = bytes_left_next - 8'd1;
        phase_next = (bytes_left_next == 8'd0) ? i2cm_pkg::PH_SPD : i2cm_pkg::PH_RXR;
      end
      i2cm_pkg::PH_SPD: begin
        sda_level_next = 1'b0;
        phase_next     = i2cm_pkg::PH_SPH;
      end
      i2cm_pkg::PH_SPH: begin
        scl_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_SPU;
      end
      i2cm_pkg::PH_SPU: begin
        sda_level_next    = 1'b1;
        res_next.done_res = 1'b1;
        phase_next        = i2cm_pkg::PH_IDLE;
      end
      default: begin
        // idle with no request
        res_next.busy_res = 1'b0;
        phase_next        = i2cm_pkg::PH_IDLE;
      end
    endcase

    res_next.scl_out   = scl_level_next;
    res_next.sda_out   = sda_level_next;
    res_next.nack_seen = nack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cm_pkg::DEV_ADDR_RESET;
      phase          <= i2cm_pkg::PH_IDLE;
      kind           <= i2cm_pkg::KIND_DEVW;
      bit_index      <= 4'd0;
      bytes_left     <= 8'd0;
      shift_reg      <= 8'd0;
      is_read        <= 1'b0;
      reg_latch      <= 8'd0;
      nack_flag      <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      res_valid      <= 1'b0;
    end else begin
      if (cfg.valid) device_address <= cfg.device_address;
      if (pop) begin
        phase      <= phase_next;
        kind       <= kind_next;
        bit_index  <= bit_index_next;
        bytes_left <= bytes_left_next;
        shift_reg  <= shift_reg_next;
        is_read    <= is_read_next;
        reg_latch  <= reg_latch_next;
        nack_flag  <= nack_flag_next;
        scl_level  <= scl_level_next;
        sda_level  <= sda_level_next;
        res_valid  <= 1'b1;
      end else if (rsp.ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res <= res_next;
  end

  assign rsp.valid      = res_valid;
  assign rsp.scl_out    = res.scl_out;
  assign rsp.sda_out    = res.sda_out;
  assign rsp.busy_res   = res.busy_res;
  assign rsp.data_taken = res.data_taken;
  assign rsp.read_valid = res.read_valid;
  assign rsp.read_byte  = res.read_byte;
  assign rsp.last_byte  = res.last_byte;
  assign rsp.nack_seen  = res.nack_seen;
  assign rsp.done_res   = res.done_res;

endmodule

`default_nettype wire

// ----- src/i2c_register_access_master.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Path: an accepted tick item is queued in the FIFO, then stepped into the result register.
// Throughput: one tick item per clock while rsp drains the result register, set by the single sequencer step per item.
// Reset (rst, synchronous): queue and result register empty, lines released,
// device address back to 0x68.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_register_access_master_macros.svh"

// Structure
//   req -> i2cm_front : classifies each tick item (zero-length read becomes
//                       one byte) and parks it in a 2-entry FIFO.
//   FIFO -> i2cm_seq  : pops one item per clock whenever the result register
//                       is empty or being drained, runs one line step
//                       (a start, bit, ack, receive or stop step) and registers
//                       the result item toward rsp.
// The FIFO decouples the two sides: requests keep flowing while a result
// waits on rsp, and the sequencer keeps working while req idles with items
// still queued. cfg writes the device address at any handshake; it is used
// each time an address byte starts on the wire.

module i2c_register_access_master (
  input  wire logic  clk,
  input  wire logic  rst,
  i2cm_cfg_if.sink   cfg,
  i2cm_req_if.sink   req,
  i2cm_rsp_if.source rsp
);

  i2cm_pkg::tick_t head;
  logic            head_valid;
  logic            pop;

  // front: accept and queue tick items
  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // back: line sequencer and result register
  i2cm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg        (cfg),
    .rsp        (rsp)
  );

  // the sequencer only steps on a queued item
  `I2CM_ASSERT_IMP(a_pop_has_item, clk, rst, pop, head_valid)
  // an accepted item is in the queue on the next cycle
  `I2CM_ASSERT_NXT(a_accept_queues, clk, rst, req.valid && req.ready, head_valid)
  // every sequencer step leaves a result pending
  `I2CM_ASSERT_NXT(a_step_gives_result, clk, rst, pop, rsp.valid)

endmodule

`default_nettype wire
